FILE: rtl/core/hgn_pkg.sv
// Shared constants, types and hash helpers for the 2D hashed gradient noise block.
`timescale 1ns / 1ps
`default_nettype none
package hgn_pkg;

	// Stream payload widths
	localparam int unsigned POS_W       = 32;
	localparam int unsigned NOISE_W     = 18;
	localparam int unsigned IN_TDATA_W  = 2 * POS_W;
	localparam int unsigned OUT_TDATA_W = 24;

	// Hash constants
	localparam int unsigned  MIX_SHL_A = 15;
	localparam int unsigned  MIX_SHR_A = 12;
	localparam int unsigned  MIX_SHL_B = 2;
	localparam int unsigned  MIX_SHR_B = 4;
	localparam int unsigned  MIX_SHR_C = 16;
	localparam logic [31:0]  MIX_MUL   = 32'd2057;
	localparam int unsigned  SIGN_BIT  = 31;

	// Output saturation limits
	localparam logic signed [NOISE_W-1:0] NOISE_MAX = 18'sh1FFFF;
	localparam logic signed [NOISE_W-1:0] NOISE_MIN = 18'sh20000;

	// Configuration register indexes
	typedef enum logic [0:0] {
		REG_HEIGHT_SEED   = 1'b0,
		REG_GRADIENT_SEED = 1'b1
	} reg_idx_t;

	// First half of the integer hash: invert-add, xor-shift, add-shift
	function automatic logic [31:0] mix_a(input logic [31:0] k);
		logic [31:0] k1;
		logic [31:0] k2;
		k1 = ~k + (k << MIX_SHL_A);
		k2 = k1 ^ (k1 >> MIX_SHR_A);
		return k2 + (k2 << MIX_SHL_B);
	endfunction

	// Second half of the integer hash: xor-shift, constant multiply, xor-shift
	function automatic logic [31:0] mix_b(input logic [31:0] k);
		logic [31:0] k4;
		logic [31:0] k5;
		k4 = k ^ (k >> MIX_SHR_B);
		k5 = 32'(k4 * MIX_MUL);
		return k5 ^ (k5 >> MIX_SHR_C);
	endfunction

endpackage
`default_nettype wire

FILE: rtl/core/hgn_fade.sv
// Four-stage pipelined fade curve S(t) = 3t^2 - 2t^3 on an unsigned fraction.
`timescale 1ns / 1ps
`default_nettype none
module hgn_fade #(
	parameter int unsigned FRAC_BITS = 16
) (
	input  wire logic                 clk,
	input  wire logic [3:0]           en,     // load enables of the four stages, first in bit 0
	input  wire logic [FRAC_BITS-1:0] t,
	output logic      [FRAC_BITS:0]   s
);

	localparam int unsigned F   = FRAC_BITS;
	localparam int unsigned MW  = F + 2;
	localparam int unsigned SQW = 2 * F;
	localparam int unsigned PRW = 2 * F + 2;
	localparam logic [SQW-1:0] SQ_HALF = SQW'(1) << (F - 1);
	localparam logic [PRW-1:0] PR_HALF = PRW'(1) << (F - 1);
	localparam logic [MW-1:0]  THREE   = MW'(3) << F;
	localparam logic [F:0]     ONE     = (F + 1)'(1) << F;

	logic [SQW-1:0] sq_s2;
	logic [MW-1:0]  m_s2;
	logic [F-1:0]   t2_s3;
	logic [MW-1:0]  m_s3;
	logic [PRW-1:0] pr_s4;
	logic [F:0]     s_s5;

	logic [SQW-1:0] sq_rnd;
	logic [PRW-1:0] pr_rnd;
	logic [F+1:0]   s_raw;

	// Round t^2 and the fade product half up
	always_comb begin
		sq_rnd = sq_s2 + SQ_HALF;
		pr_rnd = pr_s4 + PR_HALF;
		s_raw  = pr_rnd[PRW-1:F];
	end

	// Square t, form 3 - 2t
	always_ff @(posedge clk) begin
		if (en[0]) begin
			sq_s2 <= SQW'(t) * SQW'(t);
			m_s2  <= THREE - MW'({t, 1'b0});
		end
	end

	// Scale t^2 back to the fraction format
	always_ff @(posedge clk) begin
		if (en[1]) begin
			t2_s3 <= sq_rnd[SQW-1:F];
			m_s3  <= m_s2;
		end
	end

	// Multiply t^2 by 3 - 2t
	always_ff @(posedge clk) begin
		if (en[2]) begin
			pr_s4 <= PRW'(t2_s3) * PRW'(m_s3);
		end
	end

	// Round and limit to one
	always_ff @(posedge clk) begin
		if (en[3]) begin
			s_s5 <= (s_raw > (F + 2)'(ONE)) ? ONE : s_raw[F:0];
		end
	end

	assign s = s_s5;

endmodule
`default_nettype wire

FILE: rtl/core/hashed_gradient_noise_2d.sv
// Top level of the 2D hashed gradient noise block: stream ports, seeds and the main pipeline.
`timescale 1ns / 1ps
`default_nettype none
// Takes one point per cycle unless the output side stalls (pos_x, pos_z in signed fixed
// point with FRAC_BITS fraction bits) and returns one noise value per point through a
// 16-stage pipeline: the corner hashes (z hash, x hash, seeded hash, each with a stage per
// hash half) and then the three fade-weighted blends, each given a stage for subtract,
// multiply and round. Every stage holds its own valid bit, so a stall on the output only
// fills empty stages behind it. The seeds must be written through cfg_wen/cfg_index/
// cfg_wdata only while no point is in flight; the block itself does not enforce this.
module hashed_gradient_noise_2d #(
	parameter int unsigned FRAC_BITS = 16
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// Configuration
	input  wire logic                               cfg_wen,
	input  wire logic [0:0]                         cfg_index,
	input  wire logic [31:0]                        cfg_wdata,
	// Input stream
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	input  wire logic [hgn_pkg::IN_TDATA_W-1:0]     s_tdata,   // pos_x [31:0], pos_z [63:32]
	// Output stream
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	output logic      [hgn_pkg::OUT_TDATA_W-1:0]    m_tdata    // noise_value [17:0], zeros above
);

	import hgn_pkg::*;

	localparam int unsigned F   = FRAC_BITS;
	localparam int unsigned N   = 16;          // pipeline stages
	localparam int unsigned OW  = F + 2;       // corner offset
	localparam int unsigned DW  = F + 3;       // corner dot
	localparam int unsigned DFW = F + 4;       // dot difference
	localparam int unsigned SW  = F + 1;       // fade value
	localparam int unsigned PW  = SW + 1 + DFW;
	localparam int unsigned AW  = F + 4;       // first blend results
	localparam int unsigned BW  = AW + 1;      // b - a
	localparam int unsigned P2W = SW + 1 + BW;
	localparam int unsigned EW  = AW + 2;      // final sum
	localparam int unsigned RW  = (EW > NOISE_W + 1) ? EW : NOISE_W + 1;
	localparam logic signed [PW-1:0]  P_HALF  = PW'(1) << (F - 1);
	localparam logic signed [P2W-1:0] P2_HALF = P2W'(1) << (F - 1);
	localparam logic signed [OW-1:0]  ONE     = OW'(1) << F;

	// Seeds
	logic [31:0] height_seed_q;
	logic [31:0] gradient_seed_q;

	// Valid bits and stage load enables
	logic [N:1] v_q;
	logic [N:1] en;

	// Payload pipeline (index of the unpacked arrays is the stage)
	logic [31:0]         cx0_s [1:3];
	logic [31:0]         cx1_s [1:3];
	logic [F-1:0]        fx_s  [1:9];
	logic [F-1:0]        fz_s  [1:9];
	logic [31:0]         cz0_s1;
	logic [31:0]         cz1_s1;
	logic [31:0]         hza_s2 [2];
	logic [31:0]         hz_s3  [2];
	logic [31:0]         key_s4 [4];
	logic [31:0]         ka_s5  [4];
	logic [31:0]         inner_s6 [4];
	logic [31:0]         hk_s7  [4];
	logic [31:0]         gk_s7  [4];
	logic [31:0]         hka_s8 [4];
	logic [31:0]         gka_s8 [4];
	logic [3:0]          gh_s9;
	logic [3:0]          gg_s9;
	logic signed [DW-1:0]  dot_s10 [4];
	logic signed [DFW-1:0] dif12_s11;
	logic signed [DFW-1:0] dif34_s11;
	logic signed [DW-1:0]  d1_s11;
	logic signed [DW-1:0]  d3_s11;
	logic signed [PW-1:0]  p12_s12;
	logic signed [PW-1:0]  p34_s12;
	logic signed [DW-1:0]  d1_s12;
	logic signed [DW-1:0]  d3_s12;
	logic signed [AW-1:0]  a_s13;
	logic signed [AW-1:0]  b_s13;
	logic signed [BW-1:0]  dba_s14;
	logic signed [AW-1:0]  a_s14;
	logic signed [P2W-1:0] p_s15;
	logic signed [AW-1:0]  a_s15;
	logic signed [NOISE_W-1:0] noise_s16;

	// Fade values
	logic [SW-1:0] sx_s5;
	logic [SW-1:0] sz_s5;
	logic [SW-1:0] sx_s [6:11];
	logic [SW-1:0] sz_s [6:14];

	// Input fields
	logic signed [POS_W-1:0] pos_x;
	logic signed [POS_W-1:0] pos_z;

	assign pos_x = s_tdata[POS_W-1:0];
	assign pos_z = s_tdata[IN_TDATA_W-1:POS_W];

	// Write the seeds
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			height_seed_q   <= '0;
			gradient_seed_q <= '0;
		end else if (cfg_wen) begin
			case (reg_idx_t'(cfg_index))
				REG_HEIGHT_SEED:   height_seed_q   <= cfg_wdata;
				REG_GRADIENT_SEED: gradient_seed_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// A stage loads when it is empty or its content moves on
	assign en[N] = !v_q[N] || m_tready;
	for (genvar k = 1; k < N; k++) begin : g_en
		assign en[k] = !v_q[k] || en[k+1];
	end

	// Advance the valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en[1]) begin
				v_q[1] <= s_tvalid;
			end
			for (int k = 2; k <= N; k++) begin
				if (en[k]) begin
					v_q[k] <= v_q[k-1];
				end
			end
		end
	end

	assign s_tready = en[1];
	assign m_tvalid = v_q[N];
	assign m_tdata  = {{(OUT_TDATA_W - NOISE_W){1'b0}}, noise_s16};

	// Split the point into lattice cell and fraction
	always_ff @(posedge clk) begin
		if (en[1]) begin
			cx0_s[1] <= {{F{pos_x[POS_W-1]}}, pos_x[POS_W-1:F]};
			cx1_s[1] <= {{F{pos_x[POS_W-1]}}, pos_x[POS_W-1:F]} + 32'd1;
			cz0_s1   <= {{F{pos_z[POS_W-1]}}, pos_z[POS_W-1:F]};
			cz1_s1   <= {{F{pos_z[POS_W-1]}}, pos_z[POS_W-1:F]} + 32'd1;
			fx_s[1]  <= pos_x[F-1:0];
			fz_s[1]  <= pos_z[F-1:0];
		end
	end

	// Carry cell x and the fractions along
	for (genvar k = 2; k <= 3; k++) begin : g_cx
		always_ff @(posedge clk) begin
			if (en[k]) begin
				cx0_s[k] <= cx0_s[k-1];
				cx1_s[k] <= cx1_s[k-1];
			end
		end
	end

	for (genvar k = 2; k <= 9; k++) begin : g_frac
		always_ff @(posedge clk) begin
			if (en[k]) begin
				fx_s[k] <= fx_s[k-1];
				fz_s[k] <= fz_s[k-1];
			end
		end
	end

	// Hash both z rows
	always_ff @(posedge clk) begin
		if (en[2]) begin
			hza_s2[0] <= mix_a(cz0_s1);
			hza_s2[1] <= mix_a(cz1_s1);
		end
	end

	always_ff @(posedge clk) begin
		if (en[3]) begin
			hz_s3[0] <= mix_b(hza_s2[0]);
			hz_s3[1] <= mix_b(hza_s2[1]);
		end
	end

	// Hash each corner: x plus the row hash (corner bit 0 picks x1, bit 1 picks z1)
	always_ff @(posedge clk) begin
		if (en[4]) begin
			for (int c = 0; c < 4; c++) begin
				key_s4[c] <= (c[0] ? cx1_s[3] : cx0_s[3]) + hz_s3[c[1]];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[5]) begin
			for (int c = 0; c < 4; c++) begin
				ka_s5[c] <= mix_a(key_s4[c]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[6]) begin
			for (int c = 0; c < 4; c++) begin
				inner_s6[c] <= mix_b(ka_s5[c]);
			end
		end
	end

	// Seed each corner hash twice
	always_ff @(posedge clk) begin
		if (en[7]) begin
			for (int c = 0; c < 4; c++) begin
				hk_s7[c] <= height_seed_q + inner_s6[c];
				gk_s7[c] <= gradient_seed_q + inner_s6[c];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[8]) begin
			for (int c = 0; c < 4; c++) begin
				hka_s8[c] <= mix_a(hk_s7[c]);
				gka_s8[c] <= mix_a(gk_s7[c]);
			end
		end
	end

	// Keep only the sign of each gradient component
	always_ff @(posedge clk) begin
		if (en[9]) begin
			for (int c = 0; c < 4; c++) begin
				logic [31:0] h_full;
				logic [31:0] g_full;
				h_full = mix_b(hka_s8[c]);
				g_full = mix_b(gka_s8[c]);
				gh_s9[c] <= h_full[SIGN_BIT];
				gg_s9[c] <= g_full[SIGN_BIT];
			end
		end
	end

	// Dot each gradient with the offset from its corner
	always_ff @(posedge clk) begin
		if (en[10]) begin
			for (int c = 0; c < 4; c++) begin
				logic signed [OW-1:0] ox;
				logic signed [OW-1:0] oz;
				ox = signed'(OW'(fx_s[9])) - (c[0] ? ONE : '0);
				oz = signed'(OW'(fz_s[9])) - (c[1] ? ONE : '0);
				dot_s10[c] <= (gh_s9[c] ? -DW'(ox) : DW'(0))
				            - (gg_s9[c] ? DW'(oz) : DW'(0));
			end
		end
	end

	// Fade curves run beside the hash stages
	hgn_fade #(.FRAC_BITS(FRAC_BITS)) u_fade_x (
		.clk (clk),
		.en  (en[5:2]),
		.t   (fx_s[1]),
		.s   (sx_s5)
	);

	hgn_fade #(.FRAC_BITS(FRAC_BITS)) u_fade_z (
		.clk (clk),
		.en  (en[5:2]),
		.t   (fz_s[1]),
		.s   (sz_s5)
	);

	// Carry the fade values to their blends
	always_ff @(posedge clk) begin
		if (en[6]) begin
			sx_s[6] <= sx_s5;
			sz_s[6] <= sz_s5;
		end
	end

	for (genvar k = 7; k <= 11; k++) begin : g_sx
		always_ff @(posedge clk) begin
			if (en[k]) begin
				sx_s[k] <= sx_s[k-1];
			end
		end
	end

	for (genvar k = 7; k <= 14; k++) begin : g_sz
		always_ff @(posedge clk) begin
			if (en[k]) begin
				sz_s[k] <= sz_s[k-1];
			end
		end
	end

	// Blend along x: differences
	always_ff @(posedge clk) begin
		if (en[11]) begin
			dif12_s11 <= DFW'(dot_s10[1]) - DFW'(dot_s10[0]);
			dif34_s11 <= DFW'(dot_s10[3]) - DFW'(dot_s10[2]);
			d1_s11    <= dot_s10[0];
			d3_s11    <= dot_s10[2];
		end
	end

	// Blend along x: weight
	always_ff @(posedge clk) begin
		if (en[12]) begin
			p12_s12 <= signed'({1'b0, sx_s[11]}) * dif12_s11;
			p34_s12 <= signed'({1'b0, sx_s[11]}) * dif34_s11;
			d1_s12  <= d1_s11;
			d3_s12  <= d3_s11;
		end
	end

	// Blend along x: round and add
	always_ff @(posedge clk) begin
		if (en[13]) begin
			logic signed [PW-1:0] r12;
			logic signed [PW-1:0] r34;
			r12 = p12_s12 + P_HALF;
			r34 = p34_s12 + P_HALF;
			a_s13 <= AW'(d1_s12) + signed'(r12[F+AW-1:F]);
			b_s13 <= AW'(d3_s12) + signed'(r34[F+AW-1:F]);
		end
	end

	// Blend along z
	always_ff @(posedge clk) begin
		if (en[14]) begin
			dba_s14 <= BW'(b_s13) - BW'(a_s13);
			a_s14   <= a_s13;
		end
	end

	always_ff @(posedge clk) begin
		if (en[15]) begin
			p_s15 <= signed'({1'b0, sz_s[14]}) * dba_s14;
			a_s15 <= a_s14;
		end
	end

	// Round, add and saturate into the output register
	always_ff @(posedge clk) begin
		if (en[16]) begin
			logic signed [P2W-1:0] rp;
			logic signed [EW-1:0]  sum;
			logic signed [RW-1:0]  wide;
			rp   = p_s15 + P2_HALF;
			sum  = EW'(a_s15) + EW'(signed'(rp[F+BW-1:F]));
			wide = RW'(sum);
			if (wide > RW'(NOISE_MAX)) begin
				noise_s16 <= NOISE_MAX;
			end else if (wide < RW'(NOISE_MIN)) begin
				noise_s16 <= NOISE_MIN;
			end else begin
				noise_s16 <= wide[NOISE_W-1:0];
			end
		end
	end

endmodule
`default_nettype wire

FILE: verif/hashed_gradient_noise_2d_checker.sv
// Scoreboard for the 2D hashed gradient noise block: predicts every noise value and checks it.
`timescale 1ns / 1ps
module hashed_gradient_noise_2d_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wen,
	input  logic [0:0]                         cfg_index,
	input  logic [31:0]                        cfg_wdata,
	input  logic                               s_tvalid,
	input  logic                               s_tready,
	input  logic [hgn_pkg::IN_TDATA_W-1:0]     s_tdata,   // pos_x [31:0], pos_z [63:32]
	input  logic                               m_tvalid,
	input  logic                               m_tready,
	input  logic [hgn_pkg::OUT_TDATA_W-1:0]    m_tdata,   // noise_value [17:0], zeros above
	output int                                 mismatches,
	output int                                 pending
);
	import hgn_pkg::*;

	localparam int          FRAC       = 16;
	localparam longint      ONE        = longint'(1) << FRAC;
	localparam longint      HALF       = longint'(1) << (FRAC - 1);
	localparam logic [31:0] HASH_MUL   = 32'd2057;
	localparam longint      SAT_HIGH   = 131071;
	localparam longint      SAT_LOW    = -131072;
	localparam int          REPORT_MAX = 10;

	typedef struct {
		logic [31:0]        pos_x;
		logic [31:0]        pos_z;
		logic [NOISE_W-1:0] noise;
	} noise_sample_t;

	logic [31:0]   height_seed;
	logic [31:0]   gradient_seed;
	noise_sample_t noise_expected [$];

	// 32-bit wrapping integer hash
	function automatic logic [31:0] hash32(input logic [31:0] key);
		logic [31:0] k;
		k = ~key + (key << 15);
		k = k ^ (k >> 12);
		k = k + (k << 2);
		k = k ^ (k >> 4);
		k = k * HASH_MUL;
		k = k ^ (k >> 16);
		return k;
	endfunction

	// Round half up and drop the fraction bits
	function automatic longint round_q(input longint v);
		return (v + HALF) >>> FRAC;
	endfunction

	// Dot product of a corner gradient with the offset from that corner
	function automatic longint corner_dot(input logic [31:0] cx, input logic [31:0] cz,
			input longint ox, input longint oz);
		logic [31:0] cell_hash;
		logic [31:0] h_hash;
		logic [31:0] g_hash;
		longint      d;
		cell_hash = hash32(cx + hash32(cz));
		h_hash    = hash32(height_seed + cell_hash);
		g_hash    = hash32(gradient_seed + cell_hash);
		d = 0;
		if (h_hash[31]) d -= ox;
		if (g_hash[31]) d -= oz;
		return d;
	endfunction

	// Fade curve 3t^2 - 2t^3 in Q.16, clamped to [0, 1]
	function automatic longint fade_q(input longint t);
		longint t2;
		longint s;
		t2 = round_q(t * t);
		s  = round_q(t2 * (3 * ONE - 2 * t));
		if (s > ONE) s = ONE;
		if (s < 0) s = 0;
		return s;
	endfunction

	// Noise value for one sample point with the current seeds
	function automatic logic [NOISE_W-1:0] predict_noise(input logic signed [31:0] px,
			input logic signed [31:0] pz);
		logic [31:0] cx0;
		logic [31:0] cz0;
		longint      fx;
		longint      fz;
		longint      d1;
		longint      d2;
		longint      d3;
		longint      d4;
		longint      sx;
		longint      sz;
		longint      a;
		longint      b;
		longint      r;
		cx0 = px >>> FRAC;
		cz0 = pz >>> FRAC;
		fx  = px[FRAC-1:0];
		fz  = pz[FRAC-1:0];
		d1  = corner_dot(cx0,      cz0,      fx,       fz);
		d2  = corner_dot(cx0 + 1,  cz0,      fx - ONE, fz);
		d3  = corner_dot(cx0,      cz0 + 1,  fx,       fz - ONE);
		d4  = corner_dot(cx0 + 1,  cz0 + 1,  fx - ONE, fz - ONE);
		sx  = fade_q(fx);
		sz  = fade_q(fz);
		a   = d1 + round_q(sx * (d2 - d1));
		b   = d3 + round_q(sx * (d4 - d3));
		r   = a + round_q(sz * (b - a));
		if (r > SAT_HIGH) r = SAT_HIGH;
		if (r < SAT_LOW) r = SAT_LOW;
		return r[NOISE_W-1:0];
	endfunction

	// Predict on each accepted point, compare each accepted result, track the seeds
	always @(posedge clk or negedge arst_n) begin
		noise_sample_t sample;
		noise_sample_t oldest;
		if (!arst_n) begin
			height_seed   = '0;
			gradient_seed = '0;
			noise_expected.delete();
			mismatches    = 0;
			pending      <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				sample.pos_x = s_tdata[31:0];
				sample.pos_z = s_tdata[63:32];
				sample.noise = predict_noise(s_tdata[31:0], s_tdata[63:32]);
				noise_expected.push_back(sample);
			end
			if (m_tvalid && m_tready) begin
				if (noise_expected.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$display("noise result %h with no point outstanding", m_tdata);
				end else begin
					oldest = noise_expected.pop_front();
					if (m_tdata !== {{(OUT_TDATA_W - NOISE_W){1'b0}}, oldest.noise}) begin
						mismatches++;
						if (mismatches <= REPORT_MAX)
							$display("noise mismatch at x=%h z=%h: expected %h, got %h",
								oldest.pos_x, oldest.pos_z, oldest.noise, m_tdata);
					end
				end
			end
			if (cfg_wen) begin
				case (reg_idx_t'(cfg_index))
					REG_HEIGHT_SEED:   height_seed   = cfg_wdata;
					REG_GRADIENT_SEED: gradient_seed = cfg_wdata;
					default: ;
				endcase
			end
			pending <= noise_expected.size();
		end
	end

endmodule

FILE: verif/hashed_gradient_noise_2d_tb.sv
// Testbench top for the 2D hashed gradient noise block: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module hashed_gradient_noise_2d_tb;
	import hgn_pkg::*;

	localparam int SEG_ITEMS   = 172;
	localparam int SEG_COUNT   = 6;
	localparam int STALL_LIMIT = 2000;
	localparam int TAIL_CYCLES = 40;

	logic                      clk;
	logic                      arst_n;
	logic                      cfg_wen;
	logic [0:0]                cfg_index;
	logic [31:0]               cfg_wdata;
	logic                      s_tvalid;
	logic                      s_tready;
	logic [IN_TDATA_W-1:0]     s_tdata;    // pos_x [31:0], pos_z [63:32]
	logic                      m_tvalid;
	logic                      m_tready;
	logic [OUT_TDATA_W-1:0]    m_tdata;    // noise_value [17:0], zeros above
	int                        mismatches;
	int                        pending;
	int                        send_idle_pct;
	int                        recv_idle_pct;
	int                        quiet_cycles;

	hashed_gradient_noise_2d #(
		.FRAC_BITS(16)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wen  (cfg_wen),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	hashed_gradient_noise_2d_checker i_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.mismatches(mismatches),
		.pending   (pending)
	);

	// 20 ns clock
	always #10 clk = ~clk;

	// Stall the result side at random
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Abort when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || cfg_wen || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Offer one point, idling first at random, and hold it until accepted
	task automatic send_point(input logic [31:0] px, input logic [31:0] pz);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {pz, px};
		do @(posedge clk); while (!s_tready);
	endtask

	// Hold the input side until every predicted noise value has come out
	task automatic drain_points();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	// Write both seeds on back-to-back cycles
	task automatic write_seeds(input logic [31:0] hs, input logic [31:0] gs);
		cfg_wen   <= 1'b1;
		cfg_index <= REG_HEIGHT_SEED;
		cfg_wdata <= hs;
		@(posedge clk);
		cfg_index <= REG_GRADIENT_SEED;
		cfg_wdata <= gs;
		@(posedge clk);
		cfg_wen   <= 1'b0;
	endtask

	// Random coordinate: full range, small cells, edge fractions or edge cells
	function automatic logic [31:0] random_coord();
		logic [15:0] whole;
		logic [15:0] frac;
		whole = 16'($urandom);
		frac  = 16'($urandom);
		case ($urandom_range(3))
			1: whole = 16'($urandom_range(8) - 4);
			2: begin
				case ($urandom_range(3))
					0: frac = 16'h0000;
					1: frac = 16'hFFFF;
					2: frac = 16'h8000;
					default: frac = 16'h0001;
				endcase
			end
			3: begin
				case ($urandom_range(3))
					0: whole = 16'h7FFF;
					1: whole = 16'h8000;
					2: whole = 16'hFFFF;
					default: whole = 16'h0000;
				endcase
			end
			default: ;
		endcase
		return {whole, frac};
	endfunction

	initial begin
		logic [31:0] hs;
		logic [31:0] gs;
		clk           = 1'b0;
		arst_n        = 1'b0;
		cfg_wen       = 1'b0;
		cfg_index     = REG_HEIGHT_SEED;
		cfg_wdata     = '0;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		send_idle_pct = 31;
		recv_idle_pct = 50;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Field extremes, cell edges and corner wrap with reset seeds
		send_point(32'h0000_0000, 32'h0000_0000);
		send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_point(32'h8000_0000, 32'h8000_0000);
		send_point(32'h8000_0000, 32'h7FFF_FFFF);
		send_point(32'h7FFF_FFFF, 32'h8000_0000);
		send_point(32'h0000_FFFF, 32'h0000_FFFF);
		send_point(32'h0000_8000, 32'h0000_8000);
		send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_point(32'h0001_0000, 32'hFFFF_0000);
		send_point(32'h0000_FFFF, 32'h0000_0000);
		send_point(32'h0000_0001, 32'h0000_FFFF);
		send_point(32'h7FFF_0000, 32'hFFFF_8000);
		send_point(32'hFFFF_0001, 32'h0000_C000);
		send_point(32'h1234_5678, 32'h9ABC_DEF0);
		send_point(32'h0000_4000, 32'hFFFF_C000);
		send_point(32'h5555_5555, 32'hAAAA_AAAA);

		// Random points over several seed settings and idle patterns
		for (int seg = 0; seg < SEG_COUNT; seg++) begin
			case (seg / 2)
				0: begin
					send_idle_pct = 31;
					recv_idle_pct = 50;
				end
				1: begin
					send_idle_pct = 50;
					recv_idle_pct = 31;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			case (seg)
				0: begin
					hs = 32'hFFFF_FFFF;
					gs = 32'hFFFF_FFFF;
				end
				2: begin
					hs = 32'h0000_0000;
					gs = 32'hFFFF_FFFF;
				end
				4: begin
					hs = 32'hFFFF_FFFF;
					gs = 32'h0000_0000;
				end
				default: begin
					hs = $urandom;
					gs = $urandom;
				end
			endcase
			drain_points();
			write_seeds(hs, gs);
			repeat (SEG_ITEMS) send_point(random_coord(), random_coord());
		end

		drain_points();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
